@@ hw/rtl/lge_pkg.sv @@
// Shared constants and types for the life generation engine.
package lge_pkg;

  // Configuration register width and reset value
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

  // Default grid size
  localparam int GRID_ROWS    = 64;
  localparam int GRID_COLUMNS = 64;

  // Request operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam logic REG_ACTIVE_ROWS    = 1'b0;
  localparam logic REG_ACTIVE_COLUMNS = 1'b1;

  // B3/S23 neighbor counts
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  // Three-row window of one column: old row above, old current row, old row below
  typedef struct packed {
    logic above;
    logic current;
    logic below;
  } col_bits_t;

  // Window control shared by every cell of the chain
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage

@@ hw/rtl/lge_cell.sv @@
// One column cell: holds a three-row window and computes the next state of its cell.
module lge_cell (
  input  logic              clk,
  input  lge_pkg::win_ctl_t ctl,
  input  logic              load_bit,
  input  logic              active,
  input  lge_pkg::col_bits_t left_col,
  input  lge_pkg::col_bits_t right_col,
  output lge_pkg::col_bits_t own_col,
  output logic              next_bit
);

  lge_pkg::col_bits_t win;
  logic [3:0]         count;

  // Clear at the start of a generation, then shift one row down per step
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      win <= '0;
    end else if (ctl.shift) begin
      win.above   <= win.current;
      win.current <= win.below;
      win.below   <= load_bit;
    end
  end

  // Inactive columns look dead to their neighbors
  assign own_col = active ? win : '0;

  // Count the eight neighbors
  always_comb begin
    count = 4'(left_col.above) + 4'(left_col.current) + 4'(left_col.below)
          + 4'(right_col.above) + 4'(right_col.current) + 4'(right_col.below)
          + 4'(win.above) + 4'(win.below);
  end

  // Apply birth and survival
  assign next_bit = (count == 4'(lge_pkg::BIRTH_COUNT)) ||
                    (win.current && (count == 4'(lge_pkg::SURVIVE_COUNT)));

endmodule

@@ hw/rtl/lge_cell_chain.sv @@
// Row of column cells; each cell hands its window to its left and right neighbors.
module lge_cell_chain #(
  parameter int COLUMNS = lge_pkg::GRID_COLUMNS
) (
  input  logic              clk,
  input  lge_pkg::win_ctl_t ctl,
  input  logic [COLUMNS-1:0] load_row,
  input  logic [(($clog2(COLUMNS+1) > lge_pkg::CFG_W) ? $clog2(COLUMNS+1)
                 : lge_pkg::CFG_W)-1:0] used_columns,
  output logic [COLUMNS-1:0] col_active,
  output logic [COLUMNS-1:0] next_row
);

  localparam int CNT_W = ($clog2(COLUMNS+1) > lge_pkg::CFG_W) ? $clog2(COLUMNS+1)
                         : lge_pkg::CFG_W;

  lge_pkg::col_bits_t col_vis [COLUMNS];

  for (genvar j = 0; j < COLUMNS; j++) begin : g_cell
    lge_pkg::col_bits_t left_col;
    lge_pkg::col_bits_t right_col;

    // Mark columns inside the active area
    assign col_active[j] = (CNT_W'(j) < used_columns);

    // Tie the outer edges to the dead border
    if (j == 0) begin : g_left_edge
      assign left_col = '0;
    end else begin : g_left_link
      assign left_col = col_vis[j-1];
    end
    if (j == COLUMNS-1) begin : g_right_edge
      assign right_col = '0;
    end else begin : g_right_link
      assign right_col = col_vis[j+1];
    end

    lge_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_bit (load_row[j]),
      .active   (col_active[j]),
      .left_col (left_col),
      .right_col(right_col),
      .own_col  (col_vis[j]),
      .next_bit (next_row[j])
    );
  end

endmodule

@@ hw/rtl/life_generation_engine.sv @@
// Top level of the life generation engine: grid memory, sequencer and configuration.
//
// Usage: a request is taken at a clock edge where start is high and busy is low.
// operation selects write cell, read cell or advance one generation; row, column
// and value qualify a write or read. Every request gives exactly one result:
// done is high for one cycle with cell_value (the read cell, 0 otherwise).
// The receiver cannot stall; results must be taken in the cycle they appear.
// A write or an unused code gives done in the cycle after the request edge; a read
// gives it after the memory read and ST_READ, an advance once its last row is written back.
// Busy stays low for a write, so writes run one per cycle; a read holds busy through
// ST_READ and an advance through ST_ADV. The advance streams one grid row per cycle
// through the row memory's single read port into the chain of column cells, which
// writes each finished row back once it has passed the read register and the cell window.
// Configuration: write_enable, register_index and write_data set active_rows
// (index 0) or active_columns (index 1), one per write; write them only while idle.
// Reset: the grid is cleared by a pass of one row per cycle over all MAX_ROWS rows;
// busy is high during that pass and both sizes return to 64.
module life_generation_engine #(
  parameter int MAX_ROWS    = lge_pkg::GRID_ROWS,
  parameter int MAX_COLUMNS = lge_pkg::GRID_COLUMNS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                operation,
  input  logic [5:0]                row,
  input  logic [5:0]                column,
  input  logic                      value,
  output logic                      done,
  output logic                      cell_value,
  input  logic                      write_enable,
  input  logic                      register_index,
  input  logic [lge_pkg::CFG_W-1:0] write_data
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLUMNS);
  localparam int RCW = ($clog2(MAX_ROWS+3) > lge_pkg::CFG_W) ? $clog2(MAX_ROWS+3)
                       : lge_pkg::CFG_W;
  localparam int CCW = ($clog2(MAX_COLUMNS+1) > lge_pkg::CFG_W) ? $clog2(MAX_COLUMNS+1)
                       : lge_pkg::CFG_W;
  localparam int ADV_LAG = 3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ADV
  } state_t;

  state_t                    state;
  logic [RAW-1:0]            clr_row;
  logic [RCW-1:0]            step;
  logic                      rd_live;
  logic                      rd_inside;
  logic [CAW-1:0]            rd_col;
  logic [lge_pkg::CFG_W-1:0] active_rows;
  logic [lge_pkg::CFG_W-1:0] active_columns;

  logic [RCW-1:0]            used_rows;
  logic [CCW-1:0]            used_columns;
  logic [RCW-1:0]            row_ext;
  logic [CCW-1:0]            col_ext;
  logic [RAW-1:0]            row_idx;
  logic [CAW-1:0]            col_idx;
  logic                      in_area;
  logic [RCW-1:0]            adv_row;

  logic [MAX_COLUMNS-1:0]    grid_mem [MAX_ROWS];
  logic                      mem_we;
  logic [RAW-1:0]            mem_waddr;
  logic [MAX_COLUMNS-1:0]    mem_wmask;
  logic [MAX_COLUMNS-1:0]    mem_wdata;
  logic                      mem_re;
  logic [RAW-1:0]            mem_raddr;
  logic [MAX_COLUMNS-1:0]    mem_rdata;

  lge_pkg::win_ctl_t         win_ctl;
  logic [MAX_COLUMNS-1:0]    load_row;
  logic [MAX_COLUMNS-1:0]    col_active;
  logic [MAX_COLUMNS-1:0]    next_row;

  // Limit the sizes to the grid
  assign used_rows = (RCW'(active_rows) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS)
                     : RCW'(active_rows);
  assign used_columns = (CCW'(active_columns) > CCW'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS)
                        : CCW'(active_columns);

  // Decode the request address
  assign row_ext = RCW'(row);
  assign col_ext = CCW'(column);
  assign row_idx = row_ext[RAW-1:0];
  assign col_idx = col_ext[CAW-1:0];
  assign in_area = (row_ext < used_rows) && (col_ext < used_columns);
  assign adv_row = step - RCW'(ADV_LAG);

  assign busy = (state != ST_IDLE);

  // Feed rows past the last used row as dead
  assign load_row = rd_live ? mem_rdata : '0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows    <= lge_pkg::ACTIVE_RESET;
      active_columns <= lge_pkg::ACTIVE_RESET;
    end else if (write_enable) begin
      unique case (register_index)
        lge_pkg::REG_ACTIVE_ROWS:    active_rows    <= write_data;
        lge_pkg::REG_ACTIVE_COLUMNS: active_columns <= write_data;
        default: ;
      endcase
    end
  end

  // Drive the memory ports and the cell window
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wmask = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    win_ctl   = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row;
        mem_wmask = '1;
      end
      ST_IDLE: begin
        if (start) begin
          case (operation)
            lge_pkg::OP_WRITE: begin
              if (in_area) begin
                mem_we             = 1'b1;
                mem_waddr          = row_idx;
                mem_wmask[col_idx] = 1'b1;
                mem_wdata          = {MAX_COLUMNS{value}};
              end
            end
            lge_pkg::OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = row_idx;
            end
            lge_pkg::OP_ADVANCE: begin
              mem_re        = 1'b1;
              win_ctl.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_READ: ;
      ST_ADV: begin
        win_ctl.shift = 1'b1;
        mem_re        = (step < used_rows);
        mem_raddr     = step[RAW-1:0];
        if (step >= RCW'(ADV_LAG)) begin
          mem_we    = 1'b1;
          mem_waddr = adv_row[RAW-1:0];
          mem_wmask = col_active;
          mem_wdata = next_row;
        end
      end
      default: ;
    endcase
  end

  // Grid row memory with per-bit write enables and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int j = 0; j < MAX_COLUMNS; j++) begin
        if (mem_wmask[j]) begin
          grid_mem[mem_waddr][j] <= mem_wdata[j];
        end
      end
    end
    if (mem_re) begin
      mem_rdata <= grid_mem[mem_raddr];
    end
  end

  // Sequencer: clear pass, request decode, read and advance
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_row    <= '0;
      step       <= '0;
      rd_live    <= 1'b0;
      done       <= 1'b0;
      cell_value <= 1'b0;
    end else begin
      done       <= 1'b0;
      cell_value <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + RAW'(1);
          if (clr_row == RAW'(MAX_ROWS-1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            case (operation)
              lge_pkg::OP_READ: begin
                state     <= ST_READ;
                rd_inside <= in_area;
                rd_col    <= col_idx;
              end
              lge_pkg::OP_ADVANCE: begin
                state   <= ST_ADV;
                step    <= RCW'(1);
                rd_live <= (used_rows != '0);
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_READ: begin
          done       <= 1'b1;
          cell_value <= rd_inside & mem_rdata[rd_col];
          state      <= ST_IDLE;
        end
        ST_ADV: begin
          rd_live <= (step < used_rows);
          step    <= step + RCW'(1);
          if (step == used_rows + RCW'(2)) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  lge_cell_chain #(
    .COLUMNS(MAX_COLUMNS)
  ) u_chain (
    .clk         (clk),
    .ctl         (win_ctl),
    .load_row    (load_row),
    .used_columns(used_columns),
    .col_active  (col_active),
    .next_row    (next_row)
  );

`ifndef SYNTHESIS
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == lge_pkg::OP_WRITE)) |=> done)
    else $error("write request gave no result in the next cycle");

  a_value_from_read: assert property (@(posedge clk) disable iff (rst)
    cell_value |-> (done && $past(state == ST_READ)))
    else $error("live cell value outside a read result");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !mem_we)
    else $error("grid written while a read is pending");

  a_adv_row_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_ADV) && mem_we) |-> (adv_row < used_rows))
    else $error("advance wrote a row outside the active area");
`endif

endmodule
